@@ rtl/oibo_pkg.sv @@
// package: types and constants shared by the offset-ordering chain
`timescale 1ns / 1ps

package oibo_pkg;

  localparam int MaxDocs = 64;
  localparam int OffW    = 64;
  localparam int IdW     = 6;
  localparam int CntW    = $clog2(MaxDocs + 1);

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0] doc_id;
    logic           last_out;
    logic           overflow;
    logic           empty_res;
  } out_t;

  typedef struct packed {
    logic            full;
    logic [IdW-1:0]  id;
    logic [OffW-1:0] offset;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StLoad  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage

@@ rtl/oibo_cell.sv @@
// one cell of the insertion chain: holds one entry, compares against the new one
`timescale 1ns / 1ps

module oibo_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oibo_pkg::cell_ctrl_t ctrl_i,
  input  oibo_pkg::cell_t     new_i,
  input  oibo_pkg::cell_t     prev_i,
  input  logic                prev_keep_i,
  input  oibo_pkg::cell_t     next_i,
  output oibo_pkg::cell_t     cell_o,
  output logic                keep_o
);

  logic                      full_q, full_d;
  logic [oibo_pkg::IdW-1:0]  id_q, id_d;
  logic [oibo_pkg::OffW-1:0] offset_q, offset_d;
  logic                      keep;

  // entry stays put if it sorts before the new one (ties: older id first)
  assign keep = full_q && (offset_q <= new_i.offset);

  always_comb begin
    full_d   = full_q;
    id_d     = id_q;
    offset_d = offset_q;
    if (ctrl_i.shift) begin
      full_d   = next_i.full;
      id_d     = next_i.id;
      offset_d = next_i.offset;
    end else if (ctrl_i.ins && !keep) begin
      if (prev_keep_i) begin
        full_d   = 1'b1;
        id_d     = new_i.id;
        offset_d = new_i.offset;
      end else begin
        full_d   = prev_i.full;
        id_d     = prev_i.id;
        offset_d = prev_i.offset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    offset_q <= offset_d;
  end

  assign cell_o = '{full: full_q, id: id_q, offset: offset_q};
  assign keep_o = keep;

endmodule

@@ rtl/order_ids_by_offset_unit.sv @@
// top level: argsort of a document directory by offset through an insertion chain
//
//  port group   direction  handshake            payload
//  in_*         in         in_valid_i/in_stall_o  oibo_pkg::in_t  (offset, last)
//  out_*        out        out_valid_o/out_stall_i oibo_pkg::out_t (doc_id, flags)
//  cfg_*        in         cfg_valid_i/cfg_ready_o 64-bit fail offset
//
//  loading takes one directory entry per cycle: each entry is compared in every
//  cell of the chain at once and slots in with a one-cell shift
//  after the entry marked last, results leave one per cycle from the chain head unless stalled,
//  one result per stored entry (the single empty result when none), input stalled meanwhile
//  reset empties the chain, clears the run count and sets the fail offset to all ones
//  a stalled result holds the chain still, so the payload does not move
`timescale 1ns / 1ps

module order_ids_by_offset_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  oibo_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output oibo_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [oibo_pkg::OffW-1:0] cfg_data_i
);

  localparam int N = oibo_pkg::MaxDocs;

  oibo_pkg::state_e          state_q, state_d;
  logic [oibo_pkg::CntW-1:0] pos_cnt_q, pos_cnt_d;
  logic                      dropped_q, dropped_d;
  logic [oibo_pkg::OffW-1:0] fail_q;

  logic                 in_acc, out_acc, has_room, end_run;
  oibo_pkg::cell_ctrl_t ctrl;
  oibo_pkg::cell_t      new_entry;
  oibo_pkg::cell_t      cells [N];
  logic [N-1:0]         keep;
  logic [N-1:0]         full_vec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= '1;
    end else if (cfg_valid_i) begin
      fail_q <= cfg_data_i;
    end
  end

  assign in_stall_o  = (state_q != oibo_pkg::StLoad);
  assign out_valid_o = (state_q == oibo_pkg::StDrain);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign has_room    = (pos_cnt_q < oibo_pkg::CntW'(N));

  assign new_entry = '{full: 1'b1, id: oibo_pkg::IdW'(pos_cnt_q), offset: in_data_i.offset};

  assign ctrl.ins   = in_acc && has_room && (in_data_i.offset != fail_q);
  assign ctrl.shift = out_acc && full_vec[0];

  // chain: cell 0 is the head, lowest offset first
  for (genvar i = 0; i < N; i++) begin : g_cell
    oibo_pkg::cell_t prev_c, next_c;
    logic            prev_keep;

    if (i == 0) begin : g_head
      assign prev_c    = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_c    = cells[i-1];
      assign prev_keep = keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    oibo_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .prev_i      (prev_c),
      .prev_keep_i (prev_keep),
      .next_i      (next_c),
      .cell_o      (cells[i]),
      .keep_o      (keep[i])
    );

    assign full_vec[i] = cells[i].full;
  end

  // result from the chain head; an empty chain gives the single empty result
  always_comb begin
    out_data_o.doc_id    = full_vec[0] ? cells[0].id : '0;
    out_data_o.last_out  = !full_vec[0] || !full_vec[1];
    out_data_o.overflow  = dropped_q;
    out_data_o.empty_res = !full_vec[0];
  end

  assign end_run = out_acc && out_data_o.last_out;

  always_comb begin
    state_d   = state_q;
    pos_cnt_d = pos_cnt_q;
    dropped_d = dropped_q;
    case (state_q)
      oibo_pkg::StLoad: begin
        if (in_acc) begin
          if (has_room) begin
            pos_cnt_d = pos_cnt_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_data_i.last) begin
            state_d = oibo_pkg::StDrain;
          end
        end
      end
      oibo_pkg::StDrain: begin
        if (end_run) begin
          state_d   = oibo_pkg::StLoad;
          pos_cnt_d = '0;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d   = oibo_pkg::StLoad;
        pos_cnt_d = '0;
        dropped_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= oibo_pkg::StLoad;
      pos_cnt_q <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_cnt_q <= pos_cnt_d;
      dropped_q <= dropped_d;
    end
  end

`ifndef ASSERT_OFF
  // occupied cells always form a run from the head
  a_full_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((full_vec + 1'b1) & full_vec) == '0)
    else $error("chain occupancy not contiguous");

  // stored entries never outnumber positions taken in the run
  a_full_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(full_vec) <= int'(pos_cnt_q))
    else $error("more stored entries than positions");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_cnt_q <= oibo_pkg::CntW'(N))
    else $error("position count beyond capacity");

  // after the final result the chain is empty and loading resumes
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_run |=> (state_q == oibo_pkg::StLoad) && (full_vec == '0) && (pos_cnt_q == '0))
    else $error("run did not end cleanly");
`endif

endmodule

@@ sim/order_ids_by_offset_unit_tb.sv @@
// testbench: order_ids_by_offset_unit checked against an argsort predictor
`timescale 1ns / 1ps

module order_ids_by_offset_unit_tb;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 200;

  class doc_order_board;
    logic [oibo_pkg::OffW-1:0] fail_offset;
    logic [oibo_pkg::OffW-1:0] chain_off[$];
    logic [oibo_pkg::IdW-1:0]  chain_id[$];
    int unsigned               run_count;
    bit                        dropped;
    oibo_pkg::out_t            expected_ids_q[$];
    int unsigned               mismatches;

    function new();
      fail_offset = '1;
      run_count   = 0;
      dropped     = 1'b0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_ids_q.size();
    endfunction

    function void add_expected(oibo_pkg::out_t res);
      expected_ids_q.insert(expected_ids_q.size(), res);
    endfunction

    // one directory entry taken by the block
    function void note_entry(oibo_pkg::in_t item);
      int             p;
      oibo_pkg::out_t res;
      if (run_count < oibo_pkg::MaxDocs) begin
        if (item.offset != fail_offset) begin
          // equal offsets keep arrival order, so the new id goes after them
          p = 0;
          while (p < chain_off.size() && chain_off[p] <= item.offset) p++;
          chain_off.insert(p, item.offset);
          chain_id.insert(p, oibo_pkg::IdW'(run_count));
        end
        run_count++;
      end else begin
        dropped = 1'b1;
      end
      if (!item.last) return;
      if (chain_id.size() == 0) begin
        res.doc_id    = '0;
        res.last_out  = 1'b1;
        res.overflow  = dropped;
        res.empty_res = 1'b1;
        add_expected(res);
      end else begin
        for (int k = 0; k < chain_id.size(); k++) begin
          res.doc_id    = chain_id[k];
          res.last_out  = (k == chain_id.size() - 1);
          res.overflow  = dropped;
          res.empty_res = 1'b0;
          add_expected(res);
        end
      end
      chain_off.delete();
      chain_id.delete();
      run_count = 0;
      dropped   = 1'b0;
    endfunction

    function void check_result(oibo_pkg::out_t got);
      oibo_pkg::out_t want;
      if (expected_ids_q.size() == 0) begin
        $error("unexpected result: doc_id %0d last_out %0b overflow %0b empty_res %0b",
               got.doc_id, got.last_out, got.overflow, got.empty_res);
        mismatches++;
        return;
      end
      want = expected_ids_q.pop_front();
      if (got.doc_id !== want.doc_id) begin
        $error("doc_id: expected %0d, actual %0d", want.doc_id, got.doc_id);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        mismatches++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0b, actual %0b", want.empty_res, got.empty_res);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  oibo_pkg::in_t             in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  oibo_pkg::out_t            out_data_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [oibo_pkg::OffW-1:0] cfg_data_i;

  doc_order_board order_board = new();
  int             burst_left;
  bit             hold_req;

  order_ids_by_offset_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offsets biased towards collisions, extremes and the marker value
  function automatic logic [oibo_pkg::OffW-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5:       return order_board.fail_offset;
      6:          return oibo_pkg::OffW'($urandom_range(0, 7));
      7:          return '0;
      8:          return '1;
      default:    return {1'b1, 31'($urandom_range(0, 3)), 32'($urandom_range(0, 3))};
    endcase
  endfunction

  task automatic send_entry(input logic [oibo_pkg::OffW-1:0] offset, input logic last);
    int gap;
    oibo_pkg::in_t item;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    item.offset = offset;
    item.last   = last;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    order_board.note_entry(item);
    burst_left--;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_entry(pick_offset(), i == len - 1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (order_board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_fail_offset(input logic [oibo_pkg::OffW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_board.fail_offset = value;
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int hold_left;
    bit hold_done;
    out_stall_i = 1'b0;
    mode = 0;
    span = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
      end
      span--;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          2:       out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= (span % 4) != 0;
        endcase
      end
    end
  end

  initial begin : monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) order_board.check_result(out_data_o);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [oibo_pkg::OffW-1:0] fail_values[4];
    int phase_items;
    int len;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    burst_left  = 0;
    hold_req    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // marker at reset value: all-ones entry skipped, ties ordered by id
    send_entry(64'd5, 1'b0);
    send_entry(64'd0, 1'b0);
    send_entry('1, 1'b0);
    send_entry(64'd5, 1'b0);
    send_entry(64'h8000_0000_0000_0000, 1'b0);
    send_entry(64'd1, 1'b1);
    // run holding only the marker gives the empty result
    send_entry('1, 1'b1);
    // single stored entry
    send_entry(64'd0, 1'b1);
    send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_entry(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    wait_idle();

    write_fail_offset('0);
    send_entry(64'd0, 1'b0);
    send_entry('1, 1'b0);
    send_entry(64'd0, 1'b0);
    send_entry(64'd7, 1'b0);
    send_entry('1, 1'b1);
    send_entry(64'd0, 1'b1);
    wait_idle();

    fail_values[0] = {$urandom, $urandom};
    fail_values[1] = '1;
    fail_values[2] = oibo_pkg::OffW'($urandom_range(0, 7));
    fail_values[3] = {$urandom, $urandom};
    for (int phase = 0; phase < 4; phase++) begin
      write_fail_offset(fail_values[phase]);
      if (phase == 2) hold_req = 1'b1;
      phase_items = 0;
      // long runs: past capacity with the last two entries dropped, and exactly full
      if (phase == 1) begin
        send_run(oibo_pkg::MaxDocs + 2);
        phase_items += oibo_pkg::MaxDocs + 2;
      end else if (phase == 3) begin
        send_run(oibo_pkg::MaxDocs);
        phase_items += oibo_pkg::MaxDocs;
      end
      while (phase_items < 62) begin
        len = $urandom_range(1, 10);
        send_run(len);
        phase_items += len;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (order_board.mismatches == 0 && order_board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ order_ids_by_offset_unit.f @@
rtl/oibo_pkg.sv
rtl/oibo_cell.sv
rtl/order_ids_by_offset_unit.sv
sim/order_ids_by_offset_unit_tb.sv
